// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lfu_pkg.sv =====
// Package with the constants and types of the LFU page replacement core.
`timescale 1ns / 1ps

package lfu_pkg;

  // Default frame count and page width.
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int IN_PAGE_W = 16;
  localparam int COUNT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int TOTAL_W   = 16;
  localparam int INDEX_W   = 3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lfu_state_t;

endpackage

// ===== design/lfu_page_replacement_core.sv =====
// Top level of the LFU page replacement core with LRU tie-break.
//
//  Channel | Signals                                   | Dir | Handshake
//  --------+-------------------------------------------+-----+--------------------
//  request | page_number                               | in  | in_valid / in_ready
//  result  | hit, frame_index, evicted_valid,          | out | out_valid / out_ready
//          | evicted_page, hit_total, fault_total      |     |
//
// Each reference is accepted, then the frame RAM is scanned (one read per cycle
// through the registered read port), and then the chosen frame is written back
// and the result loaded. One reference is in work at a time. Reset empties all
// frames at once through the valid flops. A result waiting on out_ready does not
// block a new request; only the write-back stalls until the output register is
// free.
`timescale 1ns / 1ps

module lfu_page_replacement_core
  import lfu_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_PAGE_W-1:0] page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [INDEX_W-1:0]   frame_index,
  output logic                 evicted_valid,
  output logic [IN_PAGE_W-1:0] evicted_page,
  output logic [TOTAL_W-1:0]   hit_total,
  output logic [TOTAL_W-1:0]   fault_total
);

  localparam int AW = $clog2(FRAMES);
  localparam int EW = PAGE_BITS + COUNT_W + TIME_W;
  localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam logic [AW:0] SCAN_END = (AW + 1)'(FRAMES);

  // Controller state and scan control.
  lfu_state_t state, state_next;
  logic [AW:0]   cnt;
  logic          rd_en;
  logic          upd_fire;
  logic          proc_en;
  logic [AW-1:0] proc_idx;

  // Request registers.
  logic [PAGE_BITS-1:0] req_page;
  logic [TIME_W-1:0]    time_now;

  // Scan results.
  logic                 found;
  logic [AW-1:0]        match_idx;
  logic [COUNT_W-1:0]   match_count;
  logic                 have_empty;
  logic [AW-1:0]        empty_idx;
  logic                 have_best;
  logic [AW-1:0]        best_idx;
  logic [COUNT_W-1:0]   best_count;
  logic [TIME_W-1:0]    best_time;
  logic [PAGE_BITS-1:0] best_page;

  // Frame state.
  logic [FRAMES-1:0]    valid;
  logic [EW-1:0]        rd_data;
  logic [PAGE_BITS-1:0] rd_page;
  logic [COUNT_W-1:0]   rd_count;
  logic [TIME_W-1:0]    rd_time;
  logic                 rd_valid;

  // Write-back selection.
  logic [AW-1:0]        wr_slot;
  logic [COUNT_W-1:0]   wr_count;
  logic [EW-1:0]        wr_data;
  logic                 wr_evict;
  logic [XW-1:0]        slot_ext;

  // Frame table: page, use count and last-use time per frame.
  lfu_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk     (clk),
    .we      (upd_fire),
    .wr_addr (wr_slot),
    .wr_data (wr_data),
    .re      (rd_en),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_page  = rd_data[EW-1 -: PAGE_BITS];
  assign rd_count = rd_data[TIME_W +: COUNT_W];
  assign rd_time  = rd_data[TIME_W-1:0];
  assign rd_valid = valid[proc_idx];

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == SCAN_END) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    upd_fire = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   rd_en = (cnt < SCAN_END);
      ST_UPDATE: upd_fire = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counter and read pipeline tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      proc_en <= 1'b0;
    end else begin
      proc_en <= rd_en;
      if (in_valid && in_ready) begin
        cnt <= '0;
      end else if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= cnt[AW-1:0];
  end

  // Accept a transaction and advance the saturating clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (in_valid && in_ready) begin
      if (time_now != '1) begin
        time_now <= time_now + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_page <= PAGE_BITS'(page_number);
    end
  end

  // Scan one frame per cycle: match, first empty frame, and victim.
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      have_empty <= 1'b0;
      have_best  <= 1'b0;
    end else if (in_valid && in_ready) begin
      found      <= 1'b0;
      have_empty <= 1'b0;
      have_best  <= 1'b0;
    end else if (proc_en) begin
      if (rd_valid && rd_page == req_page && !found) begin
        found <= 1'b1;
      end
      if (!rd_valid && !have_empty) begin
        have_empty <= 1'b1;
      end
      if (rd_valid) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      if (rd_valid && rd_page == req_page && !found) begin
        match_idx   <= proc_idx;
        match_count <= rd_count;
      end
      if (!rd_valid && !have_empty) begin
        empty_idx <= proc_idx;
      end
      // Lowest count wins, then oldest time; ties keep the lower index.
      if (rd_valid && (!have_best || rd_count < best_count ||
          (rd_count == best_count && rd_time < best_time))) begin
        best_idx   <= proc_idx;
        best_count <= rd_count;
        best_time  <= rd_time;
        best_page  <= rd_page;
      end
    end
  end

  // Choose the frame to write back and its new contents.
  always_comb begin
    wr_evict = 1'b0;
    wr_count = COUNT_W'(1);
    if (found) begin
      wr_slot = match_idx;
      if (match_count != '1) begin
        wr_count = match_count + 1'b1;
      end else begin
        wr_count = match_count;
      end
    end else if (have_empty) begin
      wr_slot = empty_idx;
    end else begin
      wr_slot  = best_idx;
      wr_evict = 1'b1;
    end
    wr_data  = {req_page, wr_count, time_now};
    slot_ext = XW'(wr_slot);
  end

  // Valid flops and running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      hit_total   <= '0;
      fault_total <= '0;
    end else if (upd_fire) begin
      valid[wr_slot] <= 1'b1;
      if (found) begin
        if (hit_total != '1) begin
          hit_total <= hit_total + 1'b1;
        end
      end else if (fault_total != '1) begin
        fault_total <= fault_total + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      hit           <= found;
      frame_index   <= slot_ext[INDEX_W-1:0];
      evicted_valid <= wr_evict;
      evicted_page  <= wr_evict ? IN_PAGE_W'(best_page) : '0;
    end
  end

endmodule

// ===== design/lfu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/lfu_checker.sv =====
// Port-level checker for the LFU page replacement core, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfu_checker
  import lfu_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic                 evicted_valid,
  input logic [IN_PAGE_W-1:0] evicted_page,
  input logic [TOTAL_W-1:0]   hit_total,
  input logic [TOTAL_W-1:0]   fault_total
);

  // A stalled result keeps its valid, hit flag, evicted page and totals.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hit) && $stable(evicted_page) && $stable(hit_total) && $stable(fault_total), "result changed while stalled")

  // A hit never replaces a page.
  `ASSERT_IMPL(a_hit_no_evict, clk, rst, out_valid && hit, !evicted_valid, "eviction reported on a hit")

  // Without an eviction the evicted page reads zero.
  `ASSERT_IMPL(a_evict_zero, clk, rst, out_valid && !evicted_valid, evicted_page == '0, "evicted page not zero")

  // After a transaction is accepted the scan runs before the next one.
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "request accepted during scan")

endmodule

bind lfu_page_replacement_core lfu_checker u_lfu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .hit_total     (hit_total),
  .fault_total   (fault_total)
);
